// ===== src/cpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpfm_pkg: shared types and constants of the capture period frequency meter
// Field widths, reset value of the tick rate and the sequencer states.
// ----------------------------------------------------------------------------
package cpfm_pkg;

	localparam int CAP_W     = 16;
	localparam int PERIOD_W  = 17;
	localparam int FREQ_W    = 24;
	localparam int DIV_STEPS = FREQ_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [PERIOD_W-1:0] COUNTER_SPAN    = PERIOD_W'(65536);
	localparam logic [FREQ_W-1:0]   TICK_RATE_RESET = FREQ_W'(1000000);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== src/cpfm_if.sv =====
// ----------------------------------------------------------------------------
// cpfm_if: valid/ready channels of the capture period frequency meter
// Capture input, result output and tick rate configuration write.
// ----------------------------------------------------------------------------
interface cpfm_cap_if;
	logic                       valid;
	logic                       ready;
	logic [cpfm_pkg::CAP_W-1:0] capture_value;

	modport source (output valid, output capture_value, input ready);
	modport sink   (input valid, input capture_value, output ready);
endinterface

interface cpfm_res_if;
	logic                          valid;
	logic                          ready;
	logic [cpfm_pkg::PERIOD_W-1:0] period_ticks;
	logic [cpfm_pkg::FREQ_W-1:0]   frequency;

	modport source (output valid, output period_ticks, output frequency, input ready);
	modport sink   (input valid, input period_ticks, input frequency, output ready);
endinterface

interface cpfm_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [cpfm_pkg::FREQ_W-1:0] tick_rate;

	modport source (output valid, output tick_rate, input ready);
	modport sink   (input valid, input tick_rate, output ready);
endinterface

// ===== src/capture_period_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// capture_period_frequency_meter: period and frequency from capture pairs
// A first capture is stored and the block is ready again at once.
// A second capture runs to its result word in order: the period is formed as
// it is accepted, then the radix-2 restoring divide runs, then one load.
// No new capture is accepted until the 24-step divide loop ends and its word is loaded.
// Reset clears the pairing state and restores the tick rate to 1000000.
// ----------------------------------------------------------------------------
module capture_period_frequency_meter (
	input  logic              clk,
	input  logic              arst_n,
	cpfm_cfg_if.sink          cfg,
	cpfm_cap_if.sink          capture,
	cpfm_res_if.source        result
);

	cpfm_pkg::state_t state_q, state_d;

	logic [cpfm_pkg::FREQ_W-1:0]   tick_rate_q;
	logic                          second_q;
	logic [cpfm_pkg::CAP_W-1:0]    first_q;
	logic [cpfm_pkg::PERIOD_W-1:0] divisor_q;
	logic [cpfm_pkg::PERIOD_W-1:0] rem_q;
	logic [cpfm_pkg::FREQ_W-1:0]   quo_q;
	logic [cpfm_pkg::STEP_W-1:0]   step_q;
	logic                          res_valid_q;
	logic [cpfm_pkg::PERIOD_W-1:0] res_period_q;
	logic [cpfm_pkg::FREQ_W-1:0]   res_freq_q;

	logic                          cap_fire;
	logic                          last_step;
	logic                          load_res;
	logic [cpfm_pkg::PERIOD_W-1:0] diff;
	logic [cpfm_pkg::PERIOD_W-1:0] period;
	logic [cpfm_pkg::PERIOD_W:0]   trial;

	assign cfg.ready = 1'b1;

	assign cap_fire  = capture.valid && capture.ready;
	assign last_step = (step_q == cpfm_pkg::STEP_W'(cpfm_pkg::DIV_STEPS - 1));

	assign diff   = {1'b0, capture.capture_value} - {1'b0, first_q};
	assign period = (capture.capture_value > first_q) ? diff
	                                                  : diff + cpfm_pkg::COUNTER_SPAN;

	assign trial = {rem_q, quo_q[cpfm_pkg::FREQ_W-1]} - {1'b0, divisor_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpfm_pkg::ST_IDLE: begin
				if (cap_fire && second_q) state_d = cpfm_pkg::ST_DIV;
			end
			cpfm_pkg::ST_DIV: begin
				if (last_step) state_d = cpfm_pkg::ST_DONE;
			end
			cpfm_pkg::ST_DONE: begin
				if (!res_valid_q || result.ready) state_d = cpfm_pkg::ST_IDLE;
			end
			default: state_d = cpfm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		capture.ready = (state_q == cpfm_pkg::ST_IDLE);
		load_res      = (state_q == cpfm_pkg::ST_DONE) && (!res_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpfm_pkg::ST_IDLE;
			tick_rate_q <= cpfm_pkg::TICK_RATE_RESET;
			second_q    <= 1'b0;
			first_q     <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) tick_rate_q <= cfg.tick_rate;
			if (cap_fire) begin
				second_q <= !second_q;
				if (!second_q) first_q <= capture.capture_value;
			end
			if (state_q == cpfm_pkg::ST_DIV) step_q <= step_q + 1'b1;
			else step_q <= '0;
			if (load_res) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cap_fire && second_q) begin
			divisor_q    <= period;
			rem_q        <= '0;
			quo_q        <= tick_rate_q;
		end else if (state_q == cpfm_pkg::ST_DIV) begin
			if (!trial[cpfm_pkg::PERIOD_W]) begin
				rem_q <= trial[cpfm_pkg::PERIOD_W-1:0];
				quo_q <= {quo_q[cpfm_pkg::FREQ_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[cpfm_pkg::PERIOD_W-2:0], quo_q[cpfm_pkg::FREQ_W-1]};
				quo_q <= {quo_q[cpfm_pkg::FREQ_W-2:0], 1'b0};
			end
		end
		if (load_res) begin
			res_period_q <= divisor_q;
			res_freq_q   <= quo_q;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.period_ticks = res_period_q;
	assign result.frequency    = res_freq_q;

`ifndef ASSERT_OFF
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cpfm_pkg::ST_DIV && last_step) |=> (state_q == cpfm_pkg::ST_DONE))
		else $error("divide did not end after its last step");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> (result.valid && state_q == cpfm_pkg::ST_IDLE))
		else $error("finished word was not presented");

	a_pair_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cpfm_pkg::ST_IDLE) |-> !second_q)
		else $error("pairing state not cleared during a divide");

	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.period_ticks != '0))
		else $error("zero period in a result word");
`endif

endmodule

// ===== tb/sv/capture_period_frequency_meter_tb.sv =====
// ----------------------------------------------------------------------------
// capture_period_frequency_meter_tb: self-checking bench of the frequency meter
// Feeds capture words, pairs them in a local model of the meter and checks
// every period and frequency word in order. It covers captures at the counter
// extremes, wrap and equal pairs, tick rate extremes, random pairs, a long
// result stall and a drained pause, with random idling on both channels.
// ----------------------------------------------------------------------------
module capture_period_frequency_meter_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int TIMEOUT_NS      = 4_000_000;

	typedef struct packed {
		logic [cpfm_pkg::PERIOD_W-1:0] period_ticks;
		logic [cpfm_pkg::FREQ_W-1:0]   frequency;
	} measurement_t;

	logic clk = 1'b0;
	logic arst_n;

	cpfm_cfg_if cfg_ch ();
	cpfm_cap_if cap_ch ();
	cpfm_res_if res_ch ();

	capture_period_frequency_meter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.capture (cap_ch),
		.result  (res_ch)
	);

	always #2 clk = ~clk;

	logic [cpfm_pkg::FREQ_W-1:0] rate_model;
	logic                        pair_open;
	logic [cpfm_pkg::CAP_W-1:0]  first_cap;
	measurement_t                pending_measurements[$];
	int                          error_count = 0;
	bit                          idle_enabled = 1'b1;
	int                          hold_off_requests = 0;

	task automatic predict_measurement(input logic [cpfm_pkg::CAP_W-1:0] value);
		measurement_t m;
		if (!pair_open) begin
			first_cap = value;
			pair_open = 1'b1;
		end else begin
			if (value > first_cap)
				m.period_ticks = cpfm_pkg::PERIOD_W'(value) - cpfm_pkg::PERIOD_W'(first_cap);
			else
				m.period_ticks = cpfm_pkg::COUNTER_SPAN - cpfm_pkg::PERIOD_W'(first_cap)
				                 + cpfm_pkg::PERIOD_W'(value);
			m.frequency = cpfm_pkg::FREQ_W'(rate_model / m.period_ticks);
			pending_measurements.push_back(m);
			pair_open = 1'b0;
		end
	endtask

	function automatic logic [cpfm_pkg::CAP_W-1:0] random_capture();
		if (!pair_open)
			return cpfm_pkg::CAP_W'($urandom);
		case ($urandom_range(0, 7)) inside
			[0:1]: return first_cap + cpfm_pkg::CAP_W'($urandom_range(1, 16));
			2: return first_cap;
			3: return first_cap - cpfm_pkg::CAP_W'($urandom_range(1, 16));
			default: return cpfm_pkg::CAP_W'($urandom);
		endcase
	endfunction

	task automatic send_capture(input logic [cpfm_pkg::CAP_W-1:0] value);
		int gap;
		if (idle_enabled && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			cap_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cap_ch.valid <= 1'b1;
		cap_ch.capture_value <= value;
		do @(posedge clk); while (!cap_ch.ready);
		predict_measurement(value);
	endtask

	task automatic wait_drained();
		cap_ch.valid <= 1'b0;
		while (pending_measurements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tick_rate(input logic [cpfm_pkg::FREQ_W-1:0] value);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.tick_rate <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		rate_model = value;
		@(posedge clk);
	endtask

	task automatic send_pair(input logic [cpfm_pkg::CAP_W-1:0] first,
	                         input logic [cpfm_pkg::CAP_W-1:0] second);
		send_capture(first);
		send_capture(second);
	endtask

	task automatic test_capture_edges();
		send_pair(16'h0000, 16'h0001);
		send_pair(16'd100, 16'd100);
		send_pair(16'hFFFF, 16'h0000);
		send_pair(16'h0000, 16'hFFFF);
		send_pair(16'h0001, 16'h0000);
		send_pair(16'hAAAA, 16'h5555);
		send_pair(16'h5555, 16'hAAAA);
		send_pair(16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_tick_rate_extremes();
		write_tick_rate(24'hFFFFFF);
		send_pair(16'h0000, 16'h0001);
		send_pair(16'h0007, 16'h0007);
		write_tick_rate(24'd1);
		send_pair(16'h0005, 16'h0006);
		send_pair(16'h0006, 16'h0008);
		write_tick_rate(24'd0);
		send_pair(16'h0000, 16'h0003);
	endtask

	task automatic test_result_hold_off();
		write_tick_rate(cpfm_pkg::TICK_RATE_RESET);
		hold_off_requests++;
		repeat (16) send_capture(random_capture());
		wait_drained();
	endtask

	task automatic test_random_rates();
		logic [cpfm_pkg::FREQ_W-1:0] rate;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: rate = 24'hFFFFFF;
				1: rate = 24'd1;
				2: rate = cpfm_pkg::FREQ_W'($urandom_range(1, 1000));
				default: rate = cpfm_pkg::FREQ_W'($urandom_range(1, 24'hFFFFFF));
			endcase
			write_tick_rate(rate);
			for (int i = 0; i < 48; i++) begin
				if (phase == 3 && i == 24)
					wait_drained();
				send_capture(random_capture());
			end
		end
	endtask

	task automatic test_steady_stream();
		write_tick_rate(cpfm_pkg::FREQ_W'($urandom_range(1, 24'hFFFFFF)));
		idle_enabled = 1'b0;
		repeat (80) send_capture(random_capture());
	endtask

	initial begin : result_ready_driver
		int hold_off_served;
		int stall;
		hold_off_served = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_requests != hold_off_served) begin
				hold_off_served++;
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 13);
				res_ch.ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		measurement_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_measurements.size() == 0) begin
				$error("unexpected result word: period_ticks %0d, frequency %0d",
					res_ch.period_ticks, res_ch.frequency);
				error_count++;
			end else begin
				want = pending_measurements.pop_front();
				if (res_ch.period_ticks !== want.period_ticks) begin
					$error("period_ticks: expected %0d, actual %0d",
						want.period_ticks, res_ch.period_ticks);
					error_count++;
				end
				if (res_ch.frequency !== want.frequency) begin
					$error("frequency: expected %0d, actual %0d",
						want.frequency, res_ch.frequency);
					error_count++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("capture_period_frequency_meter_tb: errors");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.tick_rate <= '0;
		cap_ch.valid <= 1'b0;
		cap_ch.capture_value <= '0;
		rate_model = cpfm_pkg::TICK_RATE_RESET;
		pair_open = 1'b0;
		first_cap = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_capture_edges();
		test_tick_rate_extremes();
		test_result_hold_off();
		test_random_rates();
		test_steady_stream();
		wait_drained();

		if (error_count == 0 && pending_measurements.size() == 0)
			$display("capture_period_frequency_meter_tb: clean");
		else
			$display("capture_period_frequency_meter_tb: errors");
		$finish;
	end

endmodule
